/* rtl/assert_macros.svh */
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check outside reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/nsr_pkg.sv */
package nsr_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int EST_W    = 32;
  localparam int ROOT_W   = 24;
  localparam int STATUS_W = 2;
  localparam int STEPS_W  = 7;
  localparam int CNT_W    = 8;
  localparam int PREC_W   = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [PREC_W-1:0] PREC_RESET = 16'd66;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CAP = 2'd2;

  localparam logic [ADDR_W-1:0] REG_PRECISION = 3'd0;

  typedef logic [ROOT_W-1:0]   root_t;
  typedef logic [STATUS_W-1:0] status_t;

endpackage

/* rtl/newton_square_root_top.sv */
// Square root of a signed Q16.16 operand by Newton iteration.
// Input channel: in_valid / in_stall with value; a beat is taken when
// in_valid is high and in_stall low. in_stall is high while an item is at
// work, so one item is processed at a time.
// Output channel: out_valid / out_stall with root, status, steps. The result
// sits in an output register and holds while out_stall is high; the next
// item may be taken meanwhile, and it waits at its end for the register.
// Zero and negative operands go straight to the finish state and raise
// out_valid from there. Other operands run Newton steps: each step loads
// the divider, runs the bit-serial restoring divider over FRAC_BITS + 32
// quotient bits (one quotient bit a cycle), then updates the estimate and
// compares it. MAX_STEPS bounds the number of steps. A stalled output
// register holds the finished item until it frees.
// Next item: the next beat can be taken in the cycle in which out_valid
// rises, since control returns to idle at the same edge.
// APB port: precision at address 0; pready is always high.
// Reset (rst, synchronous): precision returns to 66, control goes idle and
// any pending result is dropped. No clearing pass is needed.
`include "assert_macros.svh"

module newton_square_root_top import nsr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ROOT_W-1:0]   root,
  output logic [STATUS_W-1:0] status,
  output logic [STEPS_W-1:0]  steps,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int DIV_W = EST_W + FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state;
  logic [PREC_W-1:0]  precision;
  logic [EST_W-2:0]   operand;
  logic [EST_W-1:0]   est;
  logic [CNT_W-1:0]   cnt;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   quot;
  logic [DIV_W-1:0]   dividend;
  root_t              res_root;
  status_t            res_status;
  logic [CNT_W-1:0]   res_steps;

  logic               in_acc;
  logic               out_free;
  logic [DIV_W:0]     sum;
  logic [DIV_W-1:0]   next_val;
  logic [DIV_W-1:0]   est_ext;
  logic [DIV_W-1:0]   delta;
  logic               conv;
  logic [CNT_W-1:0]   cnt_next;
  root_t              sat_root;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_PRECISION) ? DATA_W'(precision) : '0;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign dividend = {1'b0, operand, {FRAC_BITS{1'b0}}};
  assign sum      = {1'b0, quot} + (DIV_W + 1)'(est);
  assign next_val = sum[DIV_W:1];
  assign est_ext  = DIV_W'(est);
  assign delta    = (next_val >= est_ext) ? (next_val - est_ext) : (est_ext - next_val);
  assign conv     = delta < DIV_W'(precision);
  assign cnt_next = cnt + CNT_W'(1);
  assign sat_root = (next_val > DIV_W'({ROOT_W{1'b1}})) ? {ROOT_W{1'b1}} :
                    next_val[ROOT_W-1:0];

  nsr_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (est),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PREC_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_PRECISION) begin
      precision <= pwdata[PREC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      div_start <= (in_acc && value != '0 && !value[VALUE_W-1]) ||
                   (state == S_UPD && !conv && cnt_next != CNT_W'(MAX_STEPS));
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt <= '0;
            if (value == '0 || value[VALUE_W-1]) begin
              state <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          cnt <= cnt_next;
          if (conv || cnt_next == CNT_W'(MAX_STEPS)) begin
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      operand   <= value[EST_W-2:0];
      est       <= value;
      res_root  <= '0;
      res_status <= value[VALUE_W-1] ? ST_NEG : ST_OK;
      res_steps <= '0;
    end else if (state == S_UPD) begin
      est       <= next_val[EST_W-1:0];
      res_root  <= sat_root;
      res_status <= conv ? ST_OK : ST_CAP;
      res_steps <= cnt_next;
    end
    if (state == S_FIN && out_free) begin
      root   <= res_root;
      status <= res_status;
      steps  <= res_steps[STEPS_W-1:0];
    end
  end

  `ASSERT_CLK_RST(a_accept_busy, in_acc |=> (state == S_DIV || state == S_FIN),
                  "accepted beat did not start work")
  `ASSERT_CLK_RST(a_cnt_cap, cnt <= CNT_W'(MAX_STEPS), "step count beyond cap")
  `ASSERT_CLK_RST(a_div_phase, div_done |-> state == S_DIV,
                  "divider finished outside divide phase")
  `ASSERT_CLK(a_fin_free, (state == S_FIN && out_free && !rst) |=> out_valid,
              "finished result not presented")

endmodule

/* rtl/nsr_div.sv */
module nsr_div import nsr_pkg::*; #(
  parameter int DIV_W = FRAC_BITS_DEF + EST_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [EST_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DIV_W-1:0] shreg;
  logic [EST_W-1:0] rem;
  logic [EST_W-1:0] dvs;
  logic [EST_W:0]   r_sh;
  logic [EST_W+1:0] trial;
  logic             ge;

  assign r_sh     = {rem, shreg[DIV_W-1]};
  assign trial    = {1'b0, r_sh} - {2'b00, dvs};
  assign ge       = !trial[EST_W+1];
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= (divisor == '0) ? EST_W'(1) : divisor;
    end else if (busy) begin
      shreg <= {shreg[DIV_W-2:0], ge};
      rem   <= ge ? trial[EST_W-1:0] : r_sh[EST_W-1:0];
    end
  end

endmodule
